// ----- src/hss_pkg.sv -----
`default_nettype none

package hss_pkg;

    localparam int VALUE_W = 16;
    localparam int IDX_W   = 10;
    localparam int POS_W   = 10;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_READ  = 2'd3
    } hss_kind_t;

    typedef struct packed {
        logic               error;
        logic [VALUE_W-1:0] read_value;
        logic               done_res;
        logic               swap_valid;
        logic [POS_W-1:0]   swap_second;
        logic [POS_W-1:0]   swap_first;
    } hss_res_t;

endpackage

`default_nettype wire

// ----- src/heap_sort_swap_trace.sv -----
// Heap sort swap trace. Load items append 16-bit values to an on-chip
// store; step items run a max-heap sort in place and return one swap pair
// or a done result per step; read items return a stored value (zero at or
// beyond the count). Every item yields exactly one result transfer. Clear
// and load are done in the idle state, a read makes one memory read. A
// step walks sift-down levels in the sequencer around the element memory:
// a level that swaps reads the node and both children, compares and
// writes both places; a level that compares without swapping reads and
// compares; a level without children only tests; the extract phase adds
// a root swap that reads and writes root and last. A step in the build
// phase may pass over many nodes already in heap order. A new item
// is accepted only while the sequencer is idle and the output register is
// empty or transfers at the same edge.

`default_nettype none

module heap_sort_swap_trace
    import hss_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value[15:0], index[25:16]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // swap_first[9:0], swap_second[19:10],
                                        // swap_valid[20], done_res[21],
                                        // read_value[37:22], error[38]
);

    logic     core_idle;
    logic     start;
    logic     res_valid;
    hss_res_t res;
    logic     out_valid_reg;
    hss_res_t out_data_reg;

    assign s_tready = core_idle && (!out_valid_reg || m_tready);
    assign start    = s_tvalid && s_tready;

    hss_core #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .in_kind   (hss_kind_t'(s_tuser)),
        .in_value  (s_tdata[15:0]),
        .in_index  (s_tdata[25:16]),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule

`default_nettype wire

// ----- src/hss_mem.sv -----
`default_nettype none

module hss_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re_a,
    input  wire logic [AW-1:0] raddr_a,
    output logic      [DW-1:0] rdata_a,
    input  wire logic          re_b,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ----- src/hss_core.sv -----
`default_nettype none

module hss_core
    import hss_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire hss_kind_t          in_kind,
    input  wire logic [VALUE_W-1:0] in_value,
    input  wire logic [IDX_W-1:0]   in_index,
    output logic                    idle,
    output logic                    res_valid,
    output hss_res_t                res
);

    localparam int AW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW   = $clog2(MAX_ELEMENTS + 1);
    localparam int LW   = AW + 2;
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_BUILD,
        PH_EXTRACT,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OUT,
        ST_LEVEL,
        ST_RD2,
        ST_CMP,
        ST_WR2,
        ST_NOSW,
        ST_EX_RD,
        ST_EX_W1,
        ST_EX_W2
    } state_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      outer_reg, outer_next;
    logic [CW-1:0]      lim_reg, lim_next;
    logic [AW-1:0]      node_reg, node_next;
    logic [AW-1:0]      best_reg, best_next;
    logic [VALUE_W-1:0] nodev_reg, nodev_next;
    logic               rd_ok_reg, rd_ok_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic               re_a, re_b;
    logic [AW-1:0]      raddr_a, raddr_b;
    logic [VALUE_W-1:0] rdata_a, rdata_b;

    logic [LW-1:0]      lc, rc, lim_ext;
    logic [AW-1:0]      best_pos;
    logic [VALUE_W-1:0] best_val;

    hss_mem #(
        .DEPTH (MAX_ELEMENTS),
        .DW    (VALUE_W)
    ) u_mem (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .re_b    (re_b),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    assign lc      = {1'b0, node_reg, 1'b1};
    assign rc      = lc + LW'(1);
    assign lim_ext = LW'(lim_reg);
    assign idle    = (state_reg == ST_IDLE);

    always_comb
    begin
        best_pos = node_reg;
        best_val = nodev_reg;
        if (rdata_b > best_val)
        begin
            best_pos = lc[AW-1:0];
            best_val = rdata_b;
        end
        if ((rc < lim_ext) && (rdata_a > best_val))
        begin
            best_pos = rc[AW-1:0];
            best_val = rdata_a;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        outer_next = outer_reg;
        lim_next   = lim_reg;
        node_next  = node_reg;
        best_next  = best_reg;
        nodev_next = nodev_reg;
        rd_ok_next = rd_ok_reg;
        we         = 1'b0;
        waddr      = node_reg;
        wdata      = rdata_a;
        re_a       = 1'b0;
        re_b       = 1'b0;
        raddr_a    = node_reg;
        raddr_b    = lc[AW-1:0];
        res_valid  = 1'b0;
        res        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (in_kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            phase_next = PH_LOAD;
                            res_valid  = 1'b1;
                        end
                        KIND_LOAD:
                        begin
                            phase_next = PH_LOAD;
                            res_valid  = 1'b1;
                            if (count_reg < CW'(MAX_ELEMENTS))
                            begin
                                we         = 1'b1;
                                waddr      = AW'(count_reg);
                                wdata      = in_value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                res.error = 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            re_a       = 1'b1;
                            raddr_a    = AW'(in_index);
                            rd_ok_next = (CMPW'(in_index) < CMPW'(count_reg));
                            state_next = ST_RD_OUT;
                        end
                        KIND_STEP:
                        begin
                            if (phase_reg == PH_LOAD)
                            begin
                                phase_next = PH_BUILD;
                                lim_next   = count_reg;
                                outer_next = count_reg >> 1;
                                node_next  = AW'(count_reg >> 1);
                                state_next = ST_LEVEL;
                            end
                            else if (phase_reg == PH_DONE)
                            begin
                                res_valid    = 1'b1;
                                res.done_res = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_LEVEL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_OUT:
            begin
                res_valid      = 1'b1;
                res.read_value = rd_ok_reg ? rdata_a : '0;
                res.done_res   = (phase_reg == PH_DONE);
                state_next     = ST_IDLE;
            end
            ST_LEVEL:
            begin
                if (lc >= lim_ext)
                begin
                    state_next = ST_NOSW;
                end
                else
                begin
                    re_a       = 1'b1;
                    re_b       = 1'b1;
                    raddr_a    = node_reg;
                    raddr_b    = lc[AW-1:0];
                    state_next = ST_RD2;
                end
            end
            ST_RD2:
            begin
                nodev_next = rdata_a;
                re_a       = 1'b1;
                raddr_a    = rc[AW-1:0];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (best_pos == node_reg)
                begin
                    state_next = ST_NOSW;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = node_reg;
                    wdata      = best_val;
                    best_next  = best_pos;
                    state_next = ST_WR2;
                end
            end
            ST_WR2:
            begin
                we              = 1'b1;
                waddr           = best_reg;
                wdata           = nodev_reg;
                res_valid       = 1'b1;
                res.swap_first  = POS_W'(node_reg);
                res.swap_second = POS_W'(best_reg);
                res.swap_valid  = 1'b1;
                node_next       = best_reg;
                state_next      = ST_IDLE;
            end
            ST_NOSW:
            begin
                if (phase_reg == PH_BUILD)
                begin
                    state_next = ST_LEVEL;
                    if (outer_reg == '0)
                    begin
                        phase_next = PH_EXTRACT;
                        outer_next = count_reg;
                        lim_next   = '0;
                        node_next  = '0;
                    end
                    else
                    begin
                        outer_next = outer_reg - CW'(1);
                        node_next  = AW'(outer_reg - CW'(1));
                    end
                end
                else if (outer_reg == '0)
                begin
                    phase_next   = PH_DONE;
                    res_valid    = 1'b1;
                    res.done_res = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    outer_next = outer_reg - CW'(1);
                    state_next = ST_EX_RD;
                end
            end
            ST_EX_RD:
            begin
                re_a       = 1'b1;
                re_b       = 1'b1;
                raddr_a    = '0;
                raddr_b    = AW'(outer_reg);
                state_next = ST_EX_W1;
            end
            ST_EX_W1:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = rdata_b;
                state_next = ST_EX_W2;
            end
            ST_EX_W2:
            begin
                we              = 1'b1;
                waddr           = AW'(outer_reg);
                wdata           = rdata_a;
                res_valid       = 1'b1;
                res.swap_second = POS_W'(outer_reg);
                res.swap_valid  = 1'b1;
                res.done_res    = (outer_reg == '0);
                lim_next        = outer_reg;
                node_next       = '0;
                if (outer_reg == '0)
                begin
                    phase_next = PH_DONE;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_LOAD;
            count_reg <= '0;
            outer_reg <= '0;
            lim_reg   <= '0;
            node_reg  <= '0;
            best_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            outer_reg <= outer_next;
            lim_reg   <= lim_next;
            node_reg  <= node_next;
            best_reg  <= best_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nodev_reg <= nodev_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ELEMENTS))
        else $error("element count above capacity");

    a_swap_moves: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR2 |-> best_reg != node_reg)
        else $error("sift swap with itself");

    a_limit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_LOAD |-> lim_reg <= count_reg)
        else $error("heap limit above element count");

    a_rd2_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD2 |-> $past(state_reg) == ST_LEVEL)
        else $error("right child read without level read");
`endif

endmodule

`default_nettype wire
